### design/r2b_pkg.sv
`default_nettype none

package r2b_pkg;

    // field widths
    localparam int PIX_W     = 24;
    localparam int BCOL_W    = 8;
    localparam int BROW_W    = 13;
    localparam int POS_W     = 6;
    localparam int IMG_W_W   = 12;
    localparam int IMG_H_W   = 16;

    // 8x8 block geometry
    localparam int BLK_BITS  = 3;
    localparam logic [BLK_BITS-1:0] BLK_LAST = '1;
    localparam logic [POS_W-1:0]    POS_LAST = '1;

    // block index over the full 12-bit column range
    localparam int BIDX_W    = IMG_W_W - BLK_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // depth of the block request queue
    localparam int REQ_QUEUE_DEPTH = 2;

    // one block to emit
    typedef struct packed {
        logic [BIDX_W-1:0]   bcol;
        logic [BROW_W-1:0]   stripe;
        logic [BLK_BITS-1:0] last_row;
        logic [IMG_W_W-1:0]  last_col;
        logic                final_blk;
    } blk_req_t;

    // block the emitter is reading
    typedef struct packed {
        logic              busy;
        logic [BIDX_W-1:0] bcol;
    } back_status_t;

endpackage

`default_nettype wire

### design/r2b_if.sv
`default_nettype none

// raster pixel channel
interface r2b_pix_if import r2b_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// block pixel channel
interface r2b_blk_if import r2b_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  pixel_out;
    logic [BCOL_W-1:0] block_column;
    logic [BROW_W-1:0] block_row;
    logic [POS_W-1:0]  position_in_block;
    logic              last_in_block;
    logic              last_block;

    modport source (output valid, output pixel_out, output block_column,
                    output block_row, output position_in_block,
                    output last_in_block, output last_block, input ready);
    modport sink   (input valid, input pixel_out, input block_column,
                    input block_row, input position_in_block,
                    input last_in_block, input last_block, output ready);
endinterface

// register write channel
interface r2b_cfg_if import r2b_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/r2b_ram.sv
`default_nettype none

module r2b_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/r2b_queue.sv
`default_nettype none

module r2b_queue import r2b_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire blk_req_t          push_data,
    output logic                   full,
    input  wire logic              pop,
    output blk_req_t               pop_data,
    output logic                   empty,
    input  wire logic [BIDX_W-1:0] probe_bcol,
    output logic                   probe_hit
);

    localparam int PW = $clog2(DEPTH);

    blk_req_t         ent_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;

    assign full     = vld_reg[wr_ptr_reg];
    assign empty    = !vld_reg[rd_ptr_reg];
    assign pop_data = ent_reg[rd_ptr_reg];

    // does any waiting block cover this block column
    always_comb
    begin
        probe_hit = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (vld_reg[i] && ent_reg[i].bcol == probe_bcol)
            begin
                probe_hit = 1'b1;
            end
        end
    end

    // pointer and valid bit update
    always_comb
    begin
        vld_next    = vld_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            vld_next[rd_ptr_reg] = 1'b0;
            rd_ptr_next          = PW'(rd_ptr_reg + 1'b1);
        end
        if (push)
        begin
            vld_next[wr_ptr_reg] = 1'b1;
            wr_ptr_next          = PW'(wr_ptr_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            vld_reg    <= vld_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request popped from empty queue");

endmodule

`default_nettype wire

### design/r2b_front.sv
`default_nettype none

module r2b_front import r2b_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int COL_W     = 11
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    r2b_pix_if.sink                          pixels,
    r2b_cfg_if.sink                          cfg,
    output logic                             ram_we,
    output logic [BLK_BITS+COL_W-1:0]        ram_waddr,
    output logic [PIX_W-1:0]                 ram_wdata,
    output logic                             req_push,
    output blk_req_t                         req_data,
    input  wire logic                        q_full,
    input  wire logic                        q_hit,
    output logic [BIDX_W-1:0]                probe_bcol,
    input  wire back_status_t                back_st
);

    // widest usable width given the store and the register
    localparam int WCAP = (MAX_WIDTH > (2**IMG_W_W - 1)) ? (2**IMG_W_W - 1) : MAX_WIDTH;
    localparam logic [IMG_W_W-1:0] WCAP_W = IMG_W_W'(WCAP);

    logic [IMG_W_W-1:0]  width_reg, width_next;
    logic [IMG_H_W-1:0]  height_reg, height_next;
    logic [IMG_W_W-1:0]  col_reg, col_next;
    logic [BLK_BITS-1:0] row_reg, row_next;
    logic [BROW_W-1:0]   stripe_reg, stripe_next;

    logic [IMG_W_W-1:0]  last_col;
    logic [BIDX_W-1:0]   last_bcol;
    logic [IMG_H_W-1:0]  last_line;
    logic [BROW_W-1:0]   last_stripe;
    logic [BLK_BITS-1:0] last_row;
    logic [BIDX_W-1:0]   cur_bcol;
    logic                at_last_col;
    logic                blk_end;
    logic                hazard;
    logic                acc;
    logic                restart;

    // clamped image geometry
    always_comb
    begin
        if (width_reg == '0)
        begin
            last_col = '0;
        end
        else if (width_reg > WCAP_W)
        begin
            last_col = WCAP_W - 1'b1;
        end
        else
        begin
            last_col = width_reg - 1'b1;
        end
        last_line = (height_reg == '0) ? '0 : height_reg - 1'b1;
    end

    assign last_bcol   = last_col[IMG_W_W-1:BLK_BITS];
    assign last_stripe = last_line[IMG_H_W-1:BLK_BITS];
    assign last_row    = (stripe_reg == last_stripe) ? last_line[BLK_BITS-1:0] : BLK_LAST;

    // classify the incoming pixel
    assign cur_bcol    = col_reg[IMG_W_W-1:BLK_BITS];
    assign at_last_col = (col_reg >= last_col);
    assign blk_end     = (row_reg == last_row)
                         && (col_reg[BLK_BITS-1:0] == BLK_LAST || at_last_col);
    assign probe_bcol  = cur_bcol;

    // hold off while the target column still has to be read out
    assign hazard       = q_hit || (back_st.busy && back_st.bcol == cur_bcol);
    assign pixels.ready = !hazard && !(blk_end && q_full);
    assign acc          = pixels.valid && pixels.ready;
    assign cfg.ready    = 1'b1;

    // stripe store write
    assign ram_we    = acc;
    assign ram_waddr = {row_reg, COL_W'(col_reg)};
    assign ram_wdata = pixels.pixel_in;

    // block request
    assign req_push           = acc && blk_end;
    assign req_data.bcol      = cur_bcol;
    assign req_data.stripe    = stripe_reg;
    assign req_data.last_row  = last_row;
    assign req_data.last_col  = last_col;
    assign req_data.final_blk = (stripe_reg == last_stripe) && (cur_bcol == last_bcol);

    // register writes and raster position
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        stripe_next = stripe_reg;
        restart     = 1'b0;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = cfg.data[IMG_W_W-1:0];
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg.data[IMG_H_W-1:0];
                    restart     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (restart)
        begin
            col_next    = '0;
            row_next    = '0;
            stripe_next = '0;
        end
        else if (acc)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                if (row_reg >= last_row)
                begin
                    row_next    = '0;
                    stripe_next = (stripe_reg >= last_stripe) ? '0 : stripe_reg + 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMG_W_W'(8);
            height_reg <= IMG_H_W'(8);
            col_reg    <= '0;
            row_reg    <= '0;
            stripe_reg <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            stripe_reg <= stripe_next;
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT)
        |=> col_reg == '0 && row_reg == '0 && stripe_reg == '0)
        else $error("register write did not restart the frame");

endmodule

`default_nettype wire

### design/r2b_back.sv
`default_nettype none

module r2b_back import r2b_pkg::*; #(
    parameter int COL_W = 11
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_empty,
    output logic                           q_pop,
    input  wire blk_req_t                  q_data,
    output back_status_t                   status,
    output logic                           ram_re,
    output logic [BLK_BITS+COL_W-1:0]      ram_raddr,
    input  wire logic [PIX_W-1:0]          ram_rdata,
    r2b_blk_if.source                      blocks
);

    typedef struct packed {
        logic [BCOL_W-1:0] bcol;
        logic [BROW_W-1:0] brow;
        logic [POS_W-1:0]  pos;
        logic              last_in_blk;
        logic              last_blk;
    } meta_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        meta_t            meta;
    } beat_t;

    logic                active_reg, active_next;
    blk_req_t            req_reg, req_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                rd_pend_reg;
    meta_t               meta_pend_reg, issue_meta;
    logic                out_v_reg, out_v_next;
    beat_t               out_reg, out_next;
    logic                skid_v_reg, skid_v_next;
    beat_t               skid_reg, skid_next;

    logic                pop_out;
    logic [1:0]          occ_after;
    logic                issue;
    logic                last_issue;
    logic                load;
    logic [BLK_BITS-1:0] blk_i;
    logic [BLK_BITS-1:0] blk_j;
    logic [BLK_BITS-1:0] src_row;
    logic [IMG_W_W-1:0]  col_full;
    logic [IMG_W_W-1:0]  src_col;
    beat_t               in_beat;

    // read credit: output register, skid and read in flight hold at most two
    assign pop_out    = out_v_reg && blocks.ready;
    assign occ_after  = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(rd_pend_reg) - 2'(pop_out);
    assign issue      = active_reg && (occ_after < 2'd2);
    assign last_issue = issue && (pos_reg == POS_LAST);
    assign load       = !q_empty && (!active_reg || last_issue);
    assign q_pop      = load;

    assign status.busy = active_reg;
    assign status.bcol = req_reg.bcol;

    // edge replication on source row and column
    assign blk_i    = pos_reg[POS_W-1:BLK_BITS];
    assign blk_j    = pos_reg[BLK_BITS-1:0];
    assign src_row  = (blk_i < req_reg.last_row) ? blk_i : req_reg.last_row;
    assign col_full = {req_reg.bcol, blk_j};
    assign src_col  = (col_full > req_reg.last_col) ? req_reg.last_col : col_full;

    assign ram_re    = issue;
    assign ram_raddr = {src_row, COL_W'(src_col)};

    assign issue_meta.bcol        = req_reg.bcol[BCOL_W-1:0];
    assign issue_meta.brow        = req_reg.stripe;
    assign issue_meta.pos         = pos_reg;
    assign issue_meta.last_in_blk = (pos_reg == POS_LAST);
    assign issue_meta.last_blk    = req_reg.final_blk;

    // block sequencing
    always_comb
    begin
        active_next = active_reg;
        req_next    = req_reg;
        pos_next    = pos_reg;
        if (issue)
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (load)
        begin
            active_next = 1'b1;
            req_next    = q_data;
            pos_next    = '0;
        end
        else if (last_issue)
        begin
            active_next = 1'b0;
        end
    end

    // output register and skid stage
    assign in_beat = {ram_rdata, meta_pend_reg};

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        if (out_v_reg && !pop_out)
        begin
            if (!skid_v_reg && rd_pend_reg)
            begin
                skid_v_next = 1'b1;
                skid_next   = in_beat;
            end
        end
        else if (skid_v_reg)
        begin
            out_v_next  = 1'b1;
            out_next    = skid_reg;
            skid_v_next = rd_pend_reg;
            skid_next   = in_beat;
        end
        else if (rd_pend_reg)
        begin
            out_v_next  = 1'b1;
            out_next    = in_beat;
            skid_v_next = 1'b0;
        end
        else
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pos_reg     <= '0;
            rd_pend_reg <= 1'b0;
            out_v_reg   <= 1'b0;
            skid_v_reg  <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            pos_reg     <= pos_next;
            rd_pend_reg <= issue;
            out_v_reg   <= out_v_next;
            skid_v_reg  <= skid_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        meta_pend_reg <= issue_meta;
        out_reg       <= out_next;
        skid_reg      <= skid_next;
    end

    assign blocks.valid             = out_v_reg;
    assign blocks.pixel_out         = out_reg.pix;
    assign blocks.block_column      = out_reg.meta.bcol;
    assign blocks.block_row         = out_reg.meta.brow;
    assign blocks.position_in_block = out_reg.meta.pos;
    assign blocks.last_in_block     = out_reg.meta.last_in_blk;
    assign blocks.last_block        = out_reg.meta.last_blk;

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({out_v_reg, skid_v_reg, rd_pend_reg}) <= 2)
        else $error("read issued without room in output stages");

    a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
        pop_out && !out_reg.meta.last_in_blk
        |=> !out_v_reg || out_reg.meta.pos == POS_W'($past(out_reg.meta.pos) + 1'b1))
        else $error("block pixels out of order");

endmodule

`default_nettype wire

### design/raster_to_block_with_edge_padding_top.sv
// Raster to 8x8 block converter with edge padding.
// pixels: raster-order 24-bit RGB pixels, one request per accepted pixel.
// blocks: 64 requests per 8x8 block, blocks in block-row, block-column
//   order, pixels row-major; past the right or bottom edge the last real
//   column or row is repeated.
// cfg: register 0 image_width, register 1 image_height; any write to
//   either restarts the frame. Write only while the block is idle.
// Readout: a block's request is queued when its last raster pixel is
//   accepted; its 64 pixels then leave one per cycle while the receiver is ready.
// Throughput: one output pixel per cycle while the receiver is ready, set
//   by the single read port of the stripe store. Input is taken one pixel
//   per cycle and stalls only when the pixel lands in a block column still
//   waiting for readout or ends a block while the two-entry queue is full.
// Reset: width and height 8, raster position zero, no blocks pending; the
//   stripe store is not cleared and needs no clearing pass.
// Receiver stall: the output pixel holds, reads stop after a two-deep
//   output buffer fills, and raster input keeps flowing until it reaches a
//   pending block column or ends a block while the request queue is full.
`default_nettype none

module raster_to_block_with_edge_padding_top import r2b_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic clk,
    input  wire logic rst_n,
    r2b_pix_if.sink   pixels,
    r2b_blk_if.source blocks,
    r2b_cfg_if.sink   cfg
);

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int STORE_DEPTH = 2**(BLK_BITS + COL_W);

    logic                        ram_we;
    logic [BLK_BITS+COL_W-1:0]   ram_waddr;
    logic [PIX_W-1:0]            ram_wdata;
    logic                        ram_re;
    logic [BLK_BITS+COL_W-1:0]   ram_raddr;
    logic [PIX_W-1:0]            ram_rdata;

    logic                        req_push;
    blk_req_t                    req_in;
    logic                        q_full;
    logic                        q_pop;
    blk_req_t                    req_out;
    logic                        q_empty;
    logic [BIDX_W-1:0]           probe_bcol;
    logic                        q_hit;
    back_status_t                back_st;

    // stripe store: eight rows of the line width
    r2b_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // raster intake and block detection
    r2b_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .cfg        (cfg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .req_push   (req_push),
        .req_data   (req_in),
        .q_full     (q_full),
        .q_hit      (q_hit),
        .probe_bcol (probe_bcol),
        .back_st    (back_st)
    );

    // pending block requests
    r2b_queue #(
        .DEPTH (REQ_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (req_push),
        .push_data  (req_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_data   (req_out),
        .empty      (q_empty),
        .probe_bcol (probe_bcol),
        .probe_hit  (q_hit)
    );

    // block readout with edge replication
    r2b_back #(
        .COL_W (COL_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (req_out),
        .status    (back_st),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .blocks    (blocks)
    );

endmodule

`default_nettype wire

### bench/tb_raster_to_block_with_edge_padding_top.sv
`default_nettype none

module tb_raster_to_block_with_edge_padding_top import r2b_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W          = 2048;
    localparam int BLK_DIM        = 1 << BLK_BITS;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RAND_PIXELS    = 12;
    localparam int RAND_RESULTS   = 64;
    localparam int MAX_REPORTS    = 10;
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_IMAGE_HEIGHT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SOME} idle_mode_t;

    // one pixel of an 8x8 block as it leaves the block port
    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [BCOL_W-1:0] bcol;
        logic [BROW_W-1:0] brow;
        logic [POS_W-1:0]  pos;
        logic              last_pix;
        logic              last_blk;
    } block_pixel_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    r2b_pix_if pix_ch ();
    r2b_blk_if blk_ch ();
    r2b_cfg_if cfg_ch ();

    raster_to_block_with_edge_padding_top #(
        .MAX_WIDTH (MAX_W)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pix_ch),
        .blocks (blk_ch),
        .cfg    (cfg_ch)
    );

    // stimulus queues and bookkeeping
    logic [PIX_W-1:0] raster_q[$];
    reg_write_t       reg_writes_q[$];
    block_pixel_t     expected_pixels[$];
    int               pix_pushed    = 0;
    int               pixels_done   = 0;
    int               writes_pushed = 0;
    int               writes_done   = 0;
    int               results_seen  = 0;
    int               mismatch_count = 0;
    int               cycle_count   = 0;
    idle_mode_t       pix_idle_mode = IDLE_NONE;
    idle_mode_t       blk_idle_mode = IDLE_NONE;
    int               pix_gap       = 0;
    int               blk_stall     = 0;
    logic             pix_taken     = 1'b0;
    logic             blk_taken     = 1'b0;
    logic             cfg_taken     = 1'b0;
    block_pixel_t     got_pixel;
    block_pixel_t     want_pixel;

    // predicted converter state
    logic [PIX_W-1:0]   line_store [BLK_DIM][MAX_W];
    logic [IMG_W_W-1:0] width_reg  = IMG_W_W'(8);
    logic [IMG_H_W-1:0] height_reg = IMG_H_W'(8);
    int                 col_pos    = 0;
    int                 row_pos    = 0;
    int                 stripe_pos = 0;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int draw_wait(idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 10);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // register write as seen by the converter
    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = data[IMG_W_W-1:0];
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = data[IMG_H_W-1:0];
        else
            return;
        col_pos    = 0;
        row_pos    = 0;
        stripe_pos = 0;
    endfunction

    // store one raster pixel, emit the 64 block pixels it completes
    function automatic void absorb_pixel(logic [PIX_W-1:0] pix);
        int w;
        int h;
        int n_stripes;
        int last_row;
        int bcol;
        int src_row;
        int src_col;
        block_pixel_t bp;

        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        n_stripes = (h + BLK_DIM - 1) / BLK_DIM;
        last_row  = (stripe_pos + 1 >= n_stripes) ? (h - 1) % BLK_DIM : BLK_DIM - 1;
        line_store[row_pos][col_pos] = pix;

        if (row_pos == last_row && (col_pos % BLK_DIM == BLK_DIM - 1 || col_pos == w - 1))
        begin
            bcol = col_pos / BLK_DIM;
            for (int i = 0; i < BLK_DIM; i++)
            begin
                src_row = (i < last_row) ? i : last_row;
                for (int j = 0; j < BLK_DIM; j++)
                begin
                    src_col = bcol * BLK_DIM + j;
                    if (src_col > w - 1)
                        src_col = w - 1;
                    bp.pix      = line_store[src_row][src_col];
                    bp.bcol     = BCOL_W'(bcol);
                    bp.brow     = BROW_W'(stripe_pos);
                    bp.pos      = POS_W'(i * BLK_DIM + j);
                    bp.last_pix = (bp.pos == POS_LAST);
                    bp.last_blk = (stripe_pos + 1 == n_stripes) &&
                                  (bcol + 1 == (w + BLK_DIM - 1) / BLK_DIM);
                    expected_pixels.push_back(bp);
                end
            end
        end

        // advance the raster position
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            if (row_pos >= last_row)
            begin
                row_pos = 0;
                stripe_pos++;
                if (stripe_pos >= n_stripes)
                    stripe_pos = 0;
            end
            else
                row_pos++;
        end
    endfunction

    // raster pixel driver
    always @(negedge clk)
    begin
        if (!pix_ch.valid || pix_taken)
        begin
            if (pix_taken)
                pix_gap = draw_wait(pix_idle_mode);
            if (pix_gap > 0)
            begin
                pix_gap--;
                pix_ch.valid <= 1'b0;
            end
            else if (raster_q.size() > 0)
            begin
                pix_ch.valid    <= 1'b1;
                pix_ch.pixel_in <= raster_q.pop_front();
            end
            else
                pix_ch.valid <= 1'b0;
        end
    end

    // block port ready, one stall draw per request
    always @(negedge clk)
    begin
        if (!blk_ch.ready || blk_taken)
        begin
            if (blk_taken)
                blk_stall = draw_wait(blk_idle_mode);
            if (blk_stall > 0)
            begin
                blk_stall--;
                blk_ch.ready <= 1'b0;
            end
            else
                blk_ch.ready <= 1'b1;
        end
    end

    // register write driver
    always @(negedge clk)
    begin
        if (!cfg_ch.valid || cfg_taken)
        begin
            if (reg_writes_q.size() > 0)
            begin
                cfg_ch.valid <= 1'b1;
                {cfg_ch.index, cfg_ch.data} <= reg_writes_q.pop_front();
            end
            else
                cfg_ch.valid <= 1'b0;
        end
    end

    // monitor: sample requests, check block pixels, update prediction
    always @(posedge clk)
    begin
        cycle_count++;
        pix_taken = rst_n && pix_ch.valid && pix_ch.ready;
        blk_taken = rst_n && blk_ch.valid && blk_ch.ready;
        cfg_taken = rst_n && cfg_ch.valid && cfg_ch.ready;

        if (blk_taken)
        begin
            got_pixel.pix      = blk_ch.pixel_out;
            got_pixel.bcol     = blk_ch.block_column;
            got_pixel.brow     = blk_ch.block_row;
            got_pixel.pos      = blk_ch.position_in_block;
            got_pixel.last_pix = blk_ch.last_in_block;
            got_pixel.last_blk = blk_ch.last_block;
            results_seen++;
            if (expected_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected block pixel %h block %0d,%0d pos %0d",
                             $time, got_pixel.pix, got_pixel.brow, got_pixel.bcol,
                             got_pixel.pos);
            end
            else
            begin
                want_pixel = expected_pixels.pop_front();
                if (got_pixel.pix !== want_pixel.pix || got_pixel.bcol !== want_pixel.bcol ||
                    got_pixel.brow !== want_pixel.brow || got_pixel.pos !== want_pixel.pos ||
                    got_pixel.last_pix !== want_pixel.last_pix ||
                    got_pixel.last_blk !== want_pixel.last_blk)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: expected pix %h col %0d row %0d pos %0d last %b/%b,",
                                  " got pix %h col %0d row %0d pos %0d last %b/%b"},
                                 $time, want_pixel.pix, want_pixel.bcol, want_pixel.brow,
                                 want_pixel.pos, want_pixel.last_pix, want_pixel.last_blk,
                                 got_pixel.pix, got_pixel.bcol, got_pixel.brow,
                                 got_pixel.pos, got_pixel.last_pix, got_pixel.last_blk);
                end
            end
        end

        if (cfg_taken)
        begin
            apply_reg_write(cfg_ch.index, cfg_ch.data);
            writes_done++;
        end

        if (pix_taken)
        begin
            absorb_pixel(pix_ch.pixel_in);
            pixels_done++;
        end
    end

    // watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic queue_pixel(input logic [PIX_W-1:0] pix);
        raster_q.push_back(pix);
        pix_pushed++;
    endtask

    task automatic push_pixels(input int count);
        for (int k = 0; k < count; k++)
            queue_pixel(rand_pixel());
    endtask

    // all pixels in, all block pixels out, then let the pipeline drain
    task automatic wait_idle();
        while (pix_pushed != pixels_done || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        reg_write_t wr;
        wr.idx  = idx;
        wr.data = data;
        reg_writes_q.push_back(wr);
        writes_pushed++;
        while (writes_done != writes_pushed)
            @(posedge clk);
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] wdata,
                                input logic [CFG_DATA_W-1:0] hdata);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, wdata);
        write_reg(REG_IMAGE_HEIGHT, hdata);
    endtask

    // main sequence
    initial
    begin
        int rand_pixels;
        int results_base;
        int w;
        int h;
        int frame_len;
        int npix;
        int split;

        pix_ch.valid    = 1'b0;
        pix_ch.pixel_in = '0;
        blk_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry 8x8, one full frame back to back
        push_pixels(BLK_DIM * BLK_DIM);
        wait_idle();

        // single-pixel image: every pixel fills a whole block
        pix_idle_mode = IDLE_FULL;
        blk_idle_mode = IDLE_FULL;
        set_geometry(16'd1, 16'd1);
        queue_pixel('0);
        queue_pixel('1);
        queue_pixel(24'h555555);
        queue_pixel(24'haaaaaa);

        // zero width and height act as one
        set_geometry(16'h0000, 16'h0000);
        push_pixels(2);

        // padding on both edges, spare register write mid-frame keeps position
        pix_idle_mode = IDLE_NONE;
        set_geometry(16'd3, 16'd2);
        push_pixels(3);
        wait_idle();
        write_reg(REG_SPARE_LAST, 16'hffff);
        push_pixels(3);

        // right edge: second block built from a single column
        blk_idle_mode = IDLE_NONE;
        set_geometry(16'd9, 16'd1);
        push_pixels(9);

        // tallest image, first two stripes only
        pix_idle_mode = IDLE_SOME;
        set_geometry(16'd1, 16'hffff);
        push_pixels(2 * BLK_DIM);

        // widest line, first block only, upper data bits dropped
        blk_idle_mode = IDLE_SOME;
        set_geometry(16'hffff, 16'd1);
        push_pixels(BLK_DIM);

        // random small geometries, mostly whole frames
        rand_pixels  = 0;
        results_base = results_seen;
        while (rand_pixels < RAND_PIXELS || results_seen - results_base < RAND_RESULTS)
        begin
            pix_idle_mode = idle_mode_t'($urandom_range(0, 2));
            blk_idle_mode = idle_mode_t'($urandom_range(0, 2));
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            h = (w > 8) ? $urandom_range(1, 3) : $urandom_range(1, 10);
            set_geometry({4'($urandom), IMG_W_W'(w)}, CFG_DATA_W'(h));
            frame_len = w * h;
            case ($urandom_range(0, 4))
                0:       npix = $urandom_range(1, frame_len);
                1:       npix = 2 * frame_len;
                default: npix = frame_len;
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                // spare register write partway through the frame
                split = $urandom_range(0, npix);
                push_pixels(split);
                wait_idle();
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                          CFG_DATA_W'($urandom));
                push_pixels(npix - split);
            end
            else
                push_pixels(npix);
            wait_idle();
            rand_pixels += npix;
        end

        wait_idle();
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
